[hdl/sbh_pkg.sv]
`timescale 1ns / 1ps

package sbh_pkg;

    typedef logic [31:0] word_t;

    // Sixteen-entry nibble table, indexed by one nibble of the message byte.
    localparam word_t NIB_TABLE [16] = '{
        32'h243F6A88, 32'h85A308D3, 32'h3198A2E0, 32'h3707344A,
        32'h40938222, 32'h99F31D00, 32'h82EFA98E, 32'hC4E6C894,
        32'h52821E63, 32'h8D01377B, 32'hE5466CF3, 32'h4E90C6CC,
        32'h0AC29B7C, 32'h97C50DD3, 32'hF84D5B5B, 32'h54709179
    };

    // Number of rounds in the permutation.
    localparam int PERM_ROUNDS = 10;

    // Left rotation of a 32-bit word by 0 to 31 bits.
    function automatic word_t rotl32(input word_t v, input logic [4:0] n);
        logic [63:0] w;
        begin
            w = {v, v} << n;
            return w[63:32];
        end
    endfunction

    // Right rotation by one bit.
    function automatic word_t rotr1(input word_t v);
        return {v[0], v[31:1]};
    endfunction

    // The ten rounds collapse to one rotation: the half swaps add up to a
    // multiple of 32, so only the key bits that each round uses remain.
    function automatic logic [4:0] perm_amount(input word_t v);
        word_t      key;
        logic [4:0] sum_a;
        logic [4:0] sum_b;
        begin
            sum_a = '0;
            sum_b = '0;
            for (int r = 0; r < PERM_ROUNDS; r++)
            begin
                key = rotl32(v, 5'((3 * r) % 32));
                if (r < PERM_ROUNDS / 2)
                begin
                    sum_a = sum_a + {2'b00, key[2:0]};
                end
                else
                begin
                    sum_b = sum_b + {2'b00, key[2:0]};
                end
            end
            return sum_a + sum_b;
        end
    endfunction

endpackage

[hdl/sbox_rotate_byte_hash.sv]
`timescale 1ns / 1ps
// An accepted transaction that closes a message passes the input register,
// then the result register, before its hash shows on out_valid.
// Throughput: one transaction per cycle when no closing transaction waits;
// the byte absorb, the collapsed permutation rotation and the state update
// all fit between the two registers. A closing transaction waits in the
// input register while an earlier hash is still held in the result register.
// Reset (rst_n low, asynchronous): both registers empty, hash state and byte
// counter cleared to zero.

module sbox_rotate_byte_hash #(
    parameter int PERMUTE_PERIOD = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 byte_present,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sbh_pkg::word_t       hash_value
);
    import sbh_pkg::*;

    localparam int PW = (PERMUTE_PERIOD > 2) ? $clog2(PERMUTE_PERIOD) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(PERMUTE_PERIOD - 1);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       last_reg;

    // Running state.
    word_t         state_reg;
    word_t         state_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;

    // Result register.
    logic  out_valid_reg;
    word_t hash_reg;
    logic  out_valid_next;

    logic  slot_free;
    logic  proc_en;
    logic  take_in;
    word_t absorbed;
    word_t mixed;
    logic  wrap;

    // Handshake: a stage-one transaction moves on unless it needs the
    // result register and that register is still held.
    assign slot_free = !out_valid_reg || !out_stall;
    assign proc_en   = in_valid_reg && (!last_reg || slot_free);
    assign take_in   = !in_valid_reg || proc_en;
    assign in_stall  = !take_in;

    // Byte absorb: high nibble then low nibble, each followed by a rotate.
    assign absorbed = rotr1(rotr1(state_reg ^ NIB_TABLE[byte_reg[7:4]])
                            ^ NIB_TABLE[byte_reg[3:0]]);
    assign wrap     = (pos_reg == POS_LAST);
    assign mixed    = wrap ? rotl32(absorbed, perm_amount(absorbed)) : absorbed;

    // Next state and counter.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        if (proc_en)
        begin
            if (present_reg)
            begin
                state_next = mixed;
                pos_next   = wrap ? '0 : pos_reg + 1'b1;
            end
            if (last_reg)
            begin
                state_next = '0;
                pos_next   = '0;
            end
        end
    end

    // Result valid: loaded by a closing transaction, dropped when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_en && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            pos_reg       <= pos_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            byte_reg    <= data_byte;
            present_reg <= byte_present;
            last_reg    <= end_of_message;
        end
        if (proc_en && last_reg)
        begin
            hash_reg <= present_reg ? mixed : state_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // A closing transaction always lands in the result register.
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && last_reg |=> out_valid_reg)
        else $error("closing transaction did not produce a result");

    // The state and counter restart after a message ends.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en && last_reg |=> (state_reg == '0) && (pos_reg == '0))
        else $error("state not cleared after end of message");

    // The byte counter never passes the permutation period.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("byte counter out of range");

    // An empty input register never holds off the sender.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("stall raised with empty input register");

endmodule

[tb/sv/hash_check.sv]
`timescale 1ns / 1ps

// Watches both channels of the byte hash, keeps its own copy of the hash
// state and compares every hash that leaves the block against the oldest
// predicted one.
module hash_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] hash_value,
    output int          mismatches,
    output int          pending
);

    // Sixteen words selected by one nibble of the byte.
    localparam logic [31:0] NIBBLE_WORDS [16] = '{
        32'h243F6A88, 32'h85A308D3, 32'h3198A2E0, 32'h3707344A,
        32'h40938222, 32'h99F31D00, 32'h82EFA98E, 32'hC4E6C894,
        32'h52821E63, 32'h8D01377B, 32'hE5466CF3, 32'h4E90C6CC,
        32'h0AC29B7C, 32'h97C50DD3, 32'hF84D5B5B, 32'h54709179
    };

    localparam int BYTES_PER_PERMUTE = 16;
    localparam int PERMUTE_ROUNDS    = 10;

    logic [31:0] running_hash;
    int          bytes_since_permute;
    logic [31:0] expected_hashes [$];

    // Left rotation; an amount of zero leaves the word unchanged.
    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned n);
        int unsigned k;
        begin
            k = n % 32;
            if (k == 0)
            begin
                return v;
            end
            return (v << k) | (v >> (32 - k));
        end
    endfunction

    // Ten rounds of half swap plus key-driven rotation, key taken from the state.
    function automatic logic [31:0] permute_state(input logic [31:0] v);
        logic [31:0] key;
        logic [31:0] s;
        begin
            key = v;
            s = v;
            for (int r = 0; r < PERMUTE_ROUNDS; r++)
            begin
                s = {s[15:0], s[31:16]};
                s = rotate_left(s, key[2:0]);
                key = rotate_left(key, 3);
            end
            return s;
        end
    endfunction

    // Fold one byte into the running hash, high nibble first; permute after every 16th byte.
    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] s;
        begin
            s = running_hash ^ NIBBLE_WORDS[b[7:4]];
            s = {s[0], s[31:1]};
            s = s ^ NIBBLE_WORDS[b[3:0]];
            s = {s[0], s[31:1]};
            bytes_since_permute++;
            if (bytes_since_permute >= BYTES_PER_PERMUTE)
            begin
                s = permute_state(s);
                bytes_since_permute = 0;
            end
            running_hash = s;
        end
    endtask

    // Compare leaving hashes first, then predict from the accepted input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash = '0;
            bytes_since_permute = 0;
            expected_hashes.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: unexpected hash transaction, actual %08h",
                             $realtime, hash_value);
                    mismatches++;
                end
                else
                begin
                    if (hash_value !== expected_hashes[0])
                    begin
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $realtime, expected_hashes[0], hash_value);
                        mismatches++;
                    end
                    void'(expected_hashes.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                if (byte_present)
                begin
                    absorb_byte(data_byte);
                end
                if (end_of_message)
                begin
                    expected_hashes.push_back(running_hash);
                    running_hash = '0;
                    bytes_since_permute = 0;
                end
            end
            pending = expected_hashes.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] hash_value;

    int mismatches;
    int pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int sent_items = 0;

    sbox_rotate_byte_hash uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value)
    );

    hash_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // Free-running clock with a 12 ns period.
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Hard limit on the run.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_ack != hold_req)
            begin
                hold_ack = hold_req;
                out_stall <= 1'b1;
                for (int c = 0; c < LONG_HOLD_CYCLES; c++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Offer one transaction after a random idle gap and wait for its acceptance.
    task automatic offer(input logic [7:0] b, input logic present, input logic last);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            data_byte <= b;
            byte_present <= present;
            end_of_message <= last;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            if (present || last)
            begin
                sent_items++;
            end
        end
    endtask

    // Stop offering and wait until every predicted hash has come out.
    task automatic drain;
        begin
            in_valid <= 1'b0;
            do
            begin
                @(negedge clk);
            end
            while (pending != 0);
            @(posedge clk);
        end
    endtask

    // One message: random bytes with some ignored items mixed in, closed
    // either on the last byte or by a separate item without a byte.
    task automatic send_message(input int n_bytes, input bit absent_close);
        begin
            for (int i = 0; i < n_bytes; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                offer(8'($urandom_range(0, 255)), 1'b1,
                      (i == n_bytes - 1) && !absent_close);
            end
            if (absent_close || n_bytes == 0)
            begin
                offer(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
    endtask

    // Message length: mostly short, some long enough for several permutations.
    function automatic int pick_length;
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                return $urandom_range(0, 20);
            end
            return $urandom_range(21, 70);
        end
    endfunction

    // Random messages until the phase has offered its share of transactions.
    task automatic random_phase(input int idle_pct, input int stall_pct, input int items);
        int goal;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            goal = sent_items + items;
            while (sent_items < goal)
            begin
                send_message(pick_length(), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message from reset, ignored item, extreme bytes,
        // a byte closed by an item without a byte, and a full permute block.
        offer(8'hFF, 1'b0, 1'b1);
        offer(8'hA5, 1'b0, 1'b0);
        offer(8'h00, 1'b1, 1'b1);
        offer(8'hFF, 1'b1, 1'b1);
        offer(8'h5A, 1'b1, 1'b0);
        offer(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 16; i++)
        begin
            offer((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b1, i == 15);
        end
        offer(8'h3C, 1'b0, 1'b1);

        // Random, no idling on either side.
        random_phase(0, 0, 300);

        // Receiver holds off while the sender keeps pushing short messages.
        hold_req++;
        for (int m = 0; m < 30; m++)
        begin
            send_message($urandom_range(0, 3), $urandom_range(0, 3) == 0);
        end
        drain();

        random_phase(74, 0, 350);
        random_phase(0, 74, 350);
        random_phase(36, 36, 350);
        random_phase(0, 0, 200);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/sbh_pkg.sv
hdl/sbox_rotate_byte_hash.sv
tb/sv/hash_check.sv
tb/sv/testbench.sv
